[rtl/sha512_pkg.sv]
package sha512_pkg;

   localparam int WordWidth  = 64;
   localparam int BlockWords = 16;
   localparam int Rounds     = 80;
   localparam int LengthSlot = 14;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam word_type PadWord = 64'h8000000000000000;

   function automatic word_type iv_word(input logic mode, input logic [2:0] idx);
      word_type r;
      r = '0;
      if (!mode) begin
         case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
         endcase
      end else begin
         case (idx)
            3'd0: r = 64'hcbbb9d5dc1059ed8;
            3'd1: r = 64'h629a292a367cd507;
            3'd2: r = 64'h9159015a3070dd17;
            3'd3: r = 64'h152fecd8f70e5939;
            3'd4: r = 64'h67332667ffc00b31;
            3'd5: r = 64'h8eb44a8768581511;
            3'd6: r = 64'hdb0c2e0d64f98fa7;
            3'd7: r = 64'h47b5481dbefa4fa4;
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   function automatic word_type round_const(input logic [6:0] r);
      word_type k;
      case (r)
         7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
         7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
         7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
         7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
         7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

[rtl/sha512_if.sv]
interface sha512_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, message_word, valid_bytes, last_word, input ready);
   modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha512_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last_digest_word;
   modport source (output valid, digest_word, word_index, last_digest_word, input ready);
   modport sink (input valid, digest_word, word_index, last_digest_word, output ready);
endinterface

[rtl/sha512_hash_core.sv]
// a word that does not close a block is taken and the core stays ready for the next
// a full block runs the 80 rounds, then folds into the chaining value
// the last word adds padding words at one per cycle, with a step that pushes nothing
// before each fill, one or two compressions, then 8 (sha-512) or 6 (sha-384) digest
// words at one per cycle while rsp.ready is high; one request at a time
// reset: synchronous, active high; loads the sha-512 initial value, clears counters
module sha512_hash_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_wdata,
   sha512_req_if.sink        req,
   sha512_rsp_if.source      rsp
);
   import sha512_pkg::*;

   state_type      state_ff, state_in;
   logic           mode_ff, mode_in;
   word_type       cv_ff [8];
   word_type       cv_in [8];
   word_type       v_ff [8];
   word_type       v_in [8];
   word_type       w_ff [BlockWords];
   word_type       w_in [BlockWords];
   logic [4:0]     wcnt_ff, wcnt_in;
   logic [127:0]   bits_ff, bits_in;
   logic [6:0]     round_ff, round_in;
   logic [1:0]     pad_ff, pad_in;      // 0 none, 1 to block end, 2 to length, 3 pad owed
   logic [2:0]     oidx_ff, oidx_in;
   logic           after_ff, after_in;  // return to padding after compression

   word_type wr, t1, t2, s0, s1, x1, x14, pushed, keep;
   logic     push;
   logic [3:0] nb;
   logic [2:0] last_idx;

   assign last_idx = mode_ff ? 3'd5 : 3'd7;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.digest_word = cv_ff[oidx_ff];
   assign rsp.word_index = oidx_ff;
   assign rsp.last_digest_word = (oidx_ff == last_idx);

   // round datapath, schedule kept in a 16-word window
   always_comb begin
      x1  = w_ff[1];
      x14 = w_ff[14];
      s0  = {x1[0], x1[63:1]} ^ {x1[7:0], x1[63:8]} ^ (x1 >> 7);
      s1  = {x14[18:0], x14[63:19]} ^ {x14[60:0], x14[63:61]} ^ (x14 >> 6);
      wr  = (round_ff < 7'(BlockWords)) ? w_ff[0] : (w_ff[0] + s1 + w_ff[9] + s0);
      t1  = v_ff[7] + ({v_ff[4][13:0], v_ff[4][63:14]} ^ {v_ff[4][17:0], v_ff[4][63:18]}
            ^ {v_ff[4][40:0], v_ff[4][63:41]}) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
            + round_const(round_ff) + wr;
      t2  = ({v_ff[0][27:0], v_ff[0][63:28]} ^ {v_ff[0][33:0], v_ff[0][63:34]}
            ^ {v_ff[0][38:0], v_ff[0][63:39]})
            + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cv_in    = cv_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      wcnt_in  = wcnt_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      pad_in   = pad_ff;
      oidx_in  = oidx_ff;
      after_in = after_ff;
      push     = 1'b0;
      pushed   = '0;
      nb       = (req.valid_bytes > 4'd8) ? 4'd8 : req.valid_bytes;
      keep     = (nb == 4'd0) ? '0 : ~(64'hffffffffffffffff >> {nb[3:0], 3'b000});
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (!req.last_word) begin
                  bits_in = bits_ff + 128'd64;
                  push = 1'b1;
                  pushed = req.message_word;
                  after_in = 1'b0;
               end else begin
                  bits_in = bits_ff + {121'd0, nb, 3'b000};
                  after_in = 1'b1;
                  push = 1'b1;
                  if (nb == 4'd8) begin
                     pushed = req.message_word;
                     pad_in = 2'd3;   // pad word still owed
                  end else begin
                     pushed = (req.message_word & keep) | (PadWord >> {nb[3:0], 3'b000});
                     pad_in = 2'd0;
                  end
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (pad_ff == 2'd3) begin
               pushed = PadWord;
               pad_in = 2'd0;
            end else if (pad_ff == 2'd0) begin
               if (wcnt_ff > 5'(LengthSlot)) begin
                  pad_in = 2'd1;
                  push = 1'b0;
               end else begin
                  pad_in = 2'd2;
                  push = 1'b0;
               end
            end else if (pad_ff == 2'd1) begin
               pushed = '0;
               if (wcnt_ff == 5'd15) pad_in = 2'd0;
            end else begin
               if (wcnt_ff < 5'(LengthSlot)) pushed = '0;
               else if (wcnt_ff == 5'(LengthSlot)) pushed = bits_ff[127:64];
               else begin
                  pushed = bits_ff[63:0];
                  after_in = 1'b0;
                  oidx_in = 3'd0;
               end
            end
            if (!after_in && !(push && wcnt_ff == 5'd15)) state_in = ST_EMIT;
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < BlockWords - 1; i++) w_in[i] = w_ff[i+1];
            w_in[BlockWords-1] = wr;
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(Rounds - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) cv_in[i] = cv_ff[i] + v_ff[i];
            state_in = ST_IDLE;
            if (after_ff) state_in = ST_PAD;
            else if (pad_ff == 2'd2) begin
               state_in = ST_EMIT;
               oidx_in = 3'd0;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == last_idx) begin
                  state_in = ST_IDLE;
                  pad_in = 2'd0;
                  wcnt_in = '0;
                  bits_in = '0;
                  for (int i = 0; i < 8; i++) cv_in[i] = iv_word(mode_ff, 3'(i));
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // schedule fill; a full block starts the rounds
      if (push) begin
         w_in[wcnt_ff[3:0]] = pushed;
         wcnt_in = wcnt_ff + 5'd1;
         if (wcnt_ff == 5'd15) begin
            wcnt_in = '0;
            round_in = '0;
            v_in = cv_ff;
            state_in = ST_ROUND;
         end
      end
      // mode write restarts the message
      if (csr_write) begin
         mode_in = csr_wdata;
         wcnt_in = '0;
         bits_in = '0;
         for (int i = 0; i < 8; i++) cv_in[i] = iv_word(csr_wdata, 3'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= 1'b0;
         wcnt_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         pad_ff   <= '0;
         oidx_ff  <= '0;
         after_ff <= 1'b0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(1'b0, 3'(i));
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         wcnt_ff  <= wcnt_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
         pad_ff   <= pad_in;
         oidx_ff  <= oidx_in;
         after_ff <= after_in;
         cv_ff    <= cv_in;
      end
   end

   // working variables and schedule need no reset
   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

[rtl/sha512_checker.sv]
module sha512_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_digest_word
);
   // no request taken while a digest is shown
   a_excl: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request ready during digest output");
   // digest starts at word zero
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word_index == 3'd0) else $error("digest not starting at 0");
   // index advances after each taken word but the last
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_digest_word |=>
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest index skipped");
   // last word only at 5 or 7
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_digest_word |-> rsp_word_index == 3'd5 || rsp_word_index == 3'd7)
      else $error("bad last digest index");
endmodule

bind sha512_hash_core sha512_checker u_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_last_digest_word(rsp.last_digest_word)
);

[sim/tb_sha512_hash_core.sv]
module tb_sha512_hash_core;
   import sha512_pkg::*;

   typedef struct {
      word_type   data;
      logic [3:0] nbytes;
      logic       last;
   } request_type;

   typedef struct {
      word_type   data;
      logic [2:0] index;
      logic       last;
   } digest_type;

   localparam logic ModeSha512 = 1'b0;
   localparam logic ModeSha384 = 1'b1;
   localparam int   CycleLimit = 2000000;

   logic clock;
   logic reset;
   logic csr_write;
   logic csr_wdata;

   sha512_req_if req ();
   sha512_rsp_if rsp ();

   sha512_hash_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   // digest model state
   logic         hash_mode;
   word_type     chain_value[8];
   word_type     block_buf[16];
   int           block_fill;
   logic [127:0] bit_length;

   request_type pending_requests[$];
   digest_type  expected_digests[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          error_count;
   int          cycle_count;

   // clock generation
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type k_const(int r);
      word_type k[80] = '{
         64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
         64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
         64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
         64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
         64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
         64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
         64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
         64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
         64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
         64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
         64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
         64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
         64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
         64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
         64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
         64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
         64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
         64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
         64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
         64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      return k[r];
   endfunction

   function automatic word_type start_value(logic mode, int i);
      word_type v512[8] = '{
         64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
         64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      word_type v384[8] = '{
         64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
         64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
      return mode ? v384[i] : v512[i];
   endfunction

   // restart the message in the current mode
   function automatic void restart_message();
      for (int i = 0; i < 8; i++) chain_value[i] = start_value(hash_mode, i);
      bit_length = '0;
      block_fill = 0;
   endfunction

   // 80-round compression of the buffered block
   function automatic void compress_block();
      word_type w[16];
      word_type v[8];
      word_type wr, t1, t2, x1, x14;
      for (int i = 0; i < 16; i++) w[i] = block_buf[i];
      for (int i = 0; i < 8; i++) v[i] = chain_value[i];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            x1  = w[(r + 1) % 16];
            x14 = w[(r + 14) % 16];
            wr = w[r % 16] + (rotr(x14, 19) ^ rotr(x14, 61) ^ (x14 >> 6)) + w[(r + 9) % 16]
               + (rotr(x1, 1) ^ rotr(x1, 8) ^ (x1 >> 7));
            w[r % 16] = wr;
         end
         t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + wr;
         t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_value[i] += v[i];
      block_fill = 0;
   endfunction

   function automatic void append_word(word_type w);
      block_buf[block_fill] = w;
      block_fill++;
      if (block_fill >= 16) compress_block();
   endfunction

   // predict the digest words caused by one accepted request
   function automatic void hash_request(request_type it);
      int       n;
      int       count;
      word_type keep;
      digest_type d;
      if (!it.last) begin
         bit_length += 128'd64;
         append_word(it.data);
         return;
      end
      n = (it.nbytes > 8) ? 8 : int'(it.nbytes);
      bit_length += 128'(n * 8);
      if (n == 8) begin
         append_word(it.data);
         append_word(PadWord);
      end else begin
         keep = (n != 0) ? (~64'd0 << (64 - 8 * n)) : 64'd0;
         append_word((it.data & keep) | (PadWord >> (8 * n)));
      end
      if (block_fill > LengthSlot) begin
         while (block_fill != 0) append_word('0);
      end
      while (block_fill < LengthSlot) append_word('0);
      append_word(bit_length[127:64]);
      append_word(bit_length[63:0]);
      count = hash_mode ? 6 : 8;
      for (int k = 0; k < count; k++) begin
         d.data  = chain_value[k];
         d.index = 3'(k);
         d.last  = (k + 1 == count);
         expected_digests.push_back(d);
      end
      restart_message();
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid        <= 1'b1;
            req.message_word <= pending_requests[0].data;
            req.valid_bytes  <= pending_requests[0].nbytes;
            req.last_word    <= pending_requests[0].last;
            pending_requests.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // ready generation for the digest side
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // prediction on accepted requests, checking on accepted digest words
   always @(posedge clock) begin
      digest_type exp_d;
      if (!reset && req.valid && req.ready) begin
         hash_request('{req.message_word, req.valid_bytes, req.last_word});
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected digest word %h", rsp.digest_word);
            error_count++;
         end else begin
            exp_d = expected_digests.pop_front();
            if (rsp.digest_word !== exp_d.data) begin
               $error("digest_word expected %h actual %h", exp_d.data, rsp.digest_word);
               error_count++;
            end
            if (rsp.word_index !== exp_d.index) begin
               $error("word_index expected %0d actual %0d", exp_d.index, rsp.word_index);
               error_count++;
            end
            if (rsp.last_digest_word !== exp_d.last) begin
               $error("last_digest_word expected %0b actual %0b", exp_d.last,
                      rsp.last_digest_word);
               error_count++;
            end
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("** sha512_hash_core: FAILED **");
         $finish;
      end
   end

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_request(word_type d, int nb, logic last);
      request_type it;
      it.data   = d;
      it.nbytes = 4'(nb);
      it.last   = last;
      pending_requests.push_back(it);
   endfunction

   // one message of a given number of full words and a closing word
   function automatic void queue_message(int full_words, int nb);
      for (int i = 0; i < full_words; i++) queue_request(rand_word(), $urandom_range(15), 1'b0);
      queue_request(rand_word(), nb, 1'b1);
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req.valid || expected_digests.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      csr_write <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_write <= 1'b0;
      hash_mode = mode;
      restart_message();
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int words);
      int sent;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < words) begin
         int full;
         int nb;
         full = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
         nb   = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(8);
         queue_message(full, nb);
         sent += full + 1;
      end
      wait_drained();
   endtask

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      reset     = 1'b1;
      csr_write = 1'b0;
      csr_wdata = 1'b0;
      req.valid        = 1'b0;
      req.message_word = '0;
      req.valid_bytes  = '0;
      req.last_word    = 1'b0;
      rsp.ready        = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hash_mode = ModeSha512;
      restart_message();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, extremes, every tail length, block boundaries
      queue_request('0, 0, 1'b1);
      queue_request('1, 8, 1'b1);
      queue_request(64'h0123456789abcdef, 15, 1'b1);
      for (int nb = 1; nb <= 7; nb++) queue_request('1, nb, 1'b1);
      queue_message(13, 8);
      queue_message(14, 0);
      queue_message(15, 8);
      queue_message(15, 3);
      wait_drained();

      write_mode(ModeSha384);
      queue_request('0, 0, 1'b1);
      queue_request('1, 9, 1'b1);
      queue_message(16, 5);
      wait_drained();

      // random phases over both modes and idling mixes
      run_phase(0, 0, 40);
      write_mode(ModeSha512);
      run_phase(74, 0, 40);
      run_phase(0, 74, 40);
      write_mode(ModeSha384);
      run_phase(34, 34, 40);
      run_phase(74, 0, 30);
      write_mode(ModeSha512);
      run_phase(0, 0, 40);
      run_phase(34, 34, 40);

      if (error_count == 0) begin
         $display("** sha512_hash_core: PASSED **");
      end else begin
         $display("** sha512_hash_core: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
rtl/sha512_pkg.sv
rtl/sha512_if.sv
rtl/sha512_hash_core.sv
rtl/sha512_checker.sv
sim/tb_sha512_hash_core.sv
